>>> rtl/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

  // Decoder modes, one-hot.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
  localparam logic [7:0]  CH_SLASH     = 8'h2F;
  localparam logic [7:0]  CH_B         = 8'h62;
  localparam logic [7:0]  CH_F         = 8'h66;
  localparam logic [7:0]  CH_N         = 8'h6E;
  localparam logic [7:0]  CH_R         = 8'h72;
  localparam logic [7:0]  CH_T         = 8'h74;
  localparam logic [7:0]  CH_U         = 8'h75;

  localparam logic [7:0]  CTRL_BS      = 8'h08;
  localparam logic [7:0]  CTRL_FF      = 8'h0C;
  localparam logic [7:0]  CTRL_LF      = 8'h0A;
  localparam logic [7:0]  CTRL_CR      = 8'h0D;
  localparam logic [7:0]  CTRL_TAB     = 8'h09;

  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h07FF;
  localparam logic [7:0]  LEAD2        = 8'b1100_0000;
  localparam logic [7:0]  LEAD3        = 8'b1110_0000;
  localparam logic [7:0]  CONT         = 8'b1000_0000;

  localparam logic [2:0]  HEX_LEN      = 3'd4;

  // Up to three output bytes produced by one input word.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
  } grp_t;

  // Hex digit decode: valid flag and 4-bit value.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexd_t;

  function automatic hexd_t hex_digit(input logic [7:0] c);
    hexd_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h37);
    end
    return r;
  endfunction

  // UTF-8 form of a 16-bit code unit; the lead byte sits in bytes[0].
  function automatic grp_t encode_utf8(input logic [15:0] v);
    grp_t g;
    g = '0;
    if (v < ONE_BYTE_LIMIT) begin
      g.bytes[0] = v[7:0];
      g.cnt      = 2'd1;
    end else if (v <= TWO_BYTE_LIMIT) begin
      g.bytes[0] = LEAD2 | {3'b000, v[10:6]};
      g.bytes[1] = CONT | {2'b00, v[5:0]};
      g.cnt      = 2'd2;
    end else begin
      g.bytes[0] = LEAD3 | {4'b0000, v[15:12]};
      g.bytes[1] = CONT | {2'b00, v[11:6]};
      g.bytes[2] = CONT | {2'b00, v[5:0]};
      g.cnt      = 2'd3;
    end
    return g;
  endfunction

endpackage

>>> rtl/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output for unicode escapes.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------------------
//   in_     | input     | in_valid/in_stall  | in_char_byte, in_string_start,
//           |           |                    | in_string_final
//   out_    | output    | out_valid/out_stall| out_byte, out_last_in_run
//
// Each input word is decoded in the cycle it is accepted; its 0 to 3 output bytes
// go into a two-entry group queue and leave one byte per cycle from the head group
// while out_stall is low. An input word is taken every cycle while the queue has a
// free slot, so plain text runs at one word per cycle; a unicode escape holds the
// output side until its up to three bytes have left. Bytes leave from the registered queue.
// The synchronous active-low reset clears the decode state and empties the queue.
// in_stall rises only when both queue entries hold groups not yet fully sent.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_string_start,
  input  logic       in_string_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_in_run
);
  import jsu_pkg::*;

  // Decode state.
  mode_t       mode_r, mode_nxt;
  logic [15:0] hex_val_r, hex_val_nxt;
  logic [2:0]  hex_seen_r, hex_seen_nxt;
  logic        hex_stop_r, hex_stop_nxt;

  // Group queue: two entries, one byte index into the head entry.
  grp_t        grp_q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  fill_r, fill_nxt;
  logic [1:0]  byte_idx_r;

  grp_t        dec_grp;
  grp_t        head;
  hexd_t       hd;
  logic        in_acc, push, pop, out_acc;

  // The queue only refuses a word when both slots are taken.
  assign in_stall  = (fill_r == 2'd2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (fill_r != 2'd0);
  assign out_acc   = out_valid && !out_stall;

  // Decode of the current word against the current state. A start flag
  // clears the state before the word is looked at, a final flag after.
  always_comb begin
    mode_t       m;
    logic [15:0] hv;
    logic [2:0]  hs;
    logic        hst;
    m   = in_string_start ? MODE_NORMAL : mode_r;
    hv  = in_string_start ? 16'h0000 : hex_val_r;
    hs  = in_string_start ? 3'd0 : hex_seen_r;
    hst = in_string_start ? 1'b0 : hex_stop_r;
    dec_grp = '0;
    hd = hex_digit(in_char_byte);

    if (in_string_start && in_char_byte == CH_QUOTE) begin
      // Opening quote is dropped.
    end else begin
      case (m)
        MODE_ESCAPE: begin
          m = MODE_NORMAL;
          dec_grp.cnt = 2'd1;
          case (in_char_byte)
            CH_QUOTE:     dec_grp.bytes[0] = CH_QUOTE;
            CH_BACKSLASH: dec_grp.bytes[0] = CH_BACKSLASH;
            CH_SLASH:     dec_grp.bytes[0] = CH_SLASH;
            CH_B:         dec_grp.bytes[0] = CTRL_BS;
            CH_F:         dec_grp.bytes[0] = CTRL_FF;
            CH_N:         dec_grp.bytes[0] = CTRL_LF;
            CH_R:         dec_grp.bytes[0] = CTRL_CR;
            CH_T:         dec_grp.bytes[0] = CTRL_TAB;
            CH_U: begin
              dec_grp.cnt = 2'd0;
              m   = MODE_HEX;
              hv  = 16'h0000;
              hs  = 3'd0;
              hst = 1'b0;
            end
            default: dec_grp.cnt = 2'd0;  // unknown escape gives nothing
          endcase
        end
        MODE_HEX: begin
          // Digits are gathered until the first non-hex byte; the rest of the
          // four bytes are consumed without effect.
          if (!hst && hd.ok) begin
            hv = {hv[11:0], hd.val};
          end else begin
            hst = 1'b1;
          end
          hs = hs + 3'd1;
          if (hs >= HEX_LEN) begin
            dec_grp = encode_utf8(hv);
            m   = MODE_NORMAL;
            hv  = 16'h0000;
            hs  = 3'd0;
            hst = 1'b0;
          end
        end
        default: begin
          m = MODE_NORMAL;
          if (in_char_byte == CH_BACKSLASH) begin
            m = MODE_ESCAPE;
          end else begin
            dec_grp.bytes[0] = in_char_byte;
            dec_grp.cnt      = 2'd1;
          end
        end
      endcase
    end

    if (in_string_final) begin
      m   = MODE_NORMAL;
      hv  = 16'h0000;
      hs  = 3'd0;
      hst = 1'b0;
    end

    mode_nxt     = m;
    hex_val_nxt  = hv;
    hex_seen_nxt = hs;
    hex_stop_nxt = hst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      hex_val_r  <= 16'h0000;
      hex_seen_r <= 3'd0;
      hex_stop_r <= 1'b0;
    end else if (in_acc) begin
      mode_r     <= mode_nxt;
      hex_val_r  <= hex_val_nxt;
      hex_seen_r <= hex_seen_nxt;
      hex_stop_r <= hex_stop_nxt;
    end
  end

  // Head of the queue and byte selection.
  assign head = grp_q_r[rd_ptr_r];

  always_comb begin
    case (byte_idx_r)
      2'd0:    out_byte = head.bytes[0];
      2'd1:    out_byte = head.bytes[1];
      2'd2:    out_byte = head.bytes[2];
      default: out_byte = head.bytes[0];
    endcase
  end

  assign out_last_in_run = (byte_idx_r == head.cnt - 2'd1);

  // Words that produce no bytes never enter the queue.
  assign push = in_acc && (dec_grp.cnt != 2'd0);
  assign pop  = out_acc && out_last_in_run;

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      grp_q_r[wr_ptr_r] <= dec_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fill_r     <= 2'd0;
      byte_idx_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r   <= ~rd_ptr_r;
        byte_idx_r <= 2'd0;
      end else if (out_acc) begin
        byte_idx_r <= byte_idx_r + 2'd1;
      end
    end
  end

  // The queue never holds more than its two entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("group queue overfilled");

  // While a group is shown, the byte index stays inside that group.
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.cnt != 2'd0 && byte_idx_r < head.cnt))
    else $error("byte index outside head group");

  // The hex counter only runs inside a unicode escape and never reaches four.
  a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_HEX) |-> (hex_seen_r == 3'd0 && hex_val_r == 16'h0000))
    else $error("hex state left over outside unicode escape");

  a_hex_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hex_seen_r < HEX_LEN)
    else $error("hex digit count out of range");

endmodule

>>> tb/tb_json_string_unescape_utf8.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb_json_string_unescape_utf8;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  // One input word as the driver presents it.
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
  } str_word_t;

  // One output byte as the decoder is expected to send it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_byte;
  logic       in_string_start;
  logic       in_string_final;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_in_run;

  // Words waiting to be driven, and bytes the decoder still owes us.
  str_word_t  pending_words[$];
  utf8_byte_t bytes_due[$];

  // The testbench's own copy of the decoder state.
  mode_t       dec_mode;
  logic [15:0] hex_acc;
  logic [2:0]  hex_count;
  logic        hex_halted;

  int   words_taken;
  int   bytes_checked;
  int   unicode_runs;
  int   three_byte_runs;
  int   input_stall_cycles;
  int   fail_count;
  int   hold_left;
  logic hold_done;
  logic holding;
  logic in_taken;
  logic quiet;

  json_string_unescape_utf8 i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_byte    (in_char_byte),
    .in_string_start (in_string_start),
    .in_string_final (in_string_final),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_in_run (out_last_in_run)
  );

  always #4 clk = ~clk;

  // A window in the middle of the run where neither side idles, so the
  // decoder sees back-to-back words with an always-ready receiver.
  assign quiet = (words_taken >= 180) && (words_taken < 240);

  // Returns {1'b0, value} for a hex digit and 5'h10 for anything else.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'h10;
  endfunction

  // ASCII hex digit for a nibble, with letters in either case at random.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    if ($urandom_range(1) == 0) return 8'h41 + 8'(n) - 8'd10;
    return 8'h61 + 8'(n) - 8'd10;
  endfunction

  task automatic clear_decoder();
    dec_mode   = MODE_NORMAL;
    hex_acc    = '0;
    hex_count  = '0;
    hex_halted = 1'b0;
  endtask

  // Decodes one accepted word and queues the bytes it must produce.
  task automatic unescape_word(input logic [7:0] c, input logic first, input logic last);
    logic [7:0] seq [3];
    int         n;
    logic [4:0] d;
    n = 0;
    if (first) clear_decoder();

    if (first && c == CH_QUOTE) begin
      // The opening quote of a string is dropped.
      n = 0;
    end else if (dec_mode == MODE_ESCAPE) begin
      dec_mode = MODE_NORMAL;
      n = 1;
      case (c)
        CH_QUOTE, CH_BACKSLASH, CH_SLASH: seq[0] = c;
        CH_B: seq[0] = CTRL_BS;
        CH_F: seq[0] = CTRL_FF;
        CH_N: seq[0] = CTRL_LF;
        CH_R: seq[0] = CTRL_CR;
        CH_T: seq[0] = CTRL_TAB;
        CH_U: begin
          dec_mode   = MODE_HEX;
          hex_acc    = '0;
          hex_count  = '0;
          hex_halted = 1'b0;
          n = 0;
        end
        // An unknown escape character is swallowed.
        default: n = 0;
      endcase
    end else if (dec_mode == MODE_HEX) begin
      // Digits are gathered until the first non-hex byte; the rest of the
      // four bytes are consumed without changing the value.
      d = hex_nibble(c);
      if (!hex_halted && !d[4]) hex_acc = {hex_acc[11:0], d[3:0]};
      else hex_halted = 1'b1;
      hex_count = hex_count + 3'd1;
      if (hex_count >= HEX_LEN) begin
        unicode_runs++;
        if (hex_acc < ONE_BYTE_LIMIT) begin
          seq[0] = hex_acc[7:0];
          n = 1;
        end else if (hex_acc <= TWO_BYTE_LIMIT) begin
          seq[0] = LEAD2 | {3'b000, hex_acc[10:6]};
          seq[1] = CONT | {2'b00, hex_acc[5:0]};
          n = 2;
        end else begin
          // Surrogates fall in here too and go out as lone 3-byte units.
          seq[0] = LEAD3 | {4'b0000, hex_acc[15:12]};
          seq[1] = CONT | {2'b00, hex_acc[11:6]};
          seq[2] = CONT | {2'b00, hex_acc[5:0]};
          n = 3;
          three_byte_runs++;
        end
        clear_decoder();
      end
    end else begin
      dec_mode = MODE_NORMAL;
      if (c == CH_BACKSLASH) dec_mode = MODE_ESCAPE;
      else begin
        seq[0] = c;
        n = 1;
      end
    end

    // The last word of a string drops whatever escape is still open.
    if (last) clear_decoder();

    for (int k = 0; k < n; k++) bytes_due.push_back('{seq[k], k == n - 1});
  endtask

  task automatic push_word(input logic [7:0] c, input logic first, input logic last);
    pending_words.push_back('{c, first, last});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0, 1'b0);
  endtask

  // A well-formed backslash-u escape for the given code unit.
  task automatic push_unicode(input logic [15:0] v);
    push_text("\\u");
    for (int i = 3; i >= 0; i--) push_word(hex_char(v[i*4 +: 4]), 1'b0, 1'b0);
  endtask

  // A backslash-u escape with a non-hex byte somewhere in its four bytes.
  task automatic push_broken_unicode();
    int         bad_at;
    logic [7:0] c;
    logic [4:0] nib;
    bad_at = $urandom_range(3);
    push_text("\\u");
    for (int i = 0; i < 4; i++) begin
      if (i < bad_at || (i > bad_at && $urandom_range(1) == 0)) begin
        c = hex_char(4'($urandom_range(15)));
      end else begin
        c = 8'($urandom_range(255));
        nib = hex_nibble(c);
        while (!nib[4]) begin
          c = 8'($urandom_range(255));
          nib = hex_nibble(c);
        end
      end
      push_word(c, 1'b0, 1'b0);
    end
  endtask

  task automatic push_random_unicode();
    logic [15:0] v;
    logic [15:0] edges [6];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(7))
      0: v = 16'($urandom_range(16'h007F));
      1: v = 16'($urandom_range(16'h07FF, 16'h0080));
      2: v = 16'($urandom_range(16'hFFFF, 16'h0800));
      3: v = 16'($urandom_range(16'hDFFF, 16'hD800));
      4: v = edges[$urandom_range(5)];
      default: v = 16'($urandom);
    endcase
    push_unicode(v);
  endtask

  // One random piece of string content.
  task automatic push_token();
    logic [7:0] simple [8];
    logic [7:0] c;
    simple = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
    case ($urandom_range(9))
      0, 1: begin
        c = 8'($urandom_range(8'h7E, 8'h20));
        if (c == CH_BACKSLASH) c = 8'h41;
        push_word(c, 1'b0, 1'b0);
      end
      // Any byte at all, a stray backslash included.
      2: push_word(8'($urandom_range(255)), 1'b0, 1'b0);
      3, 4: begin
        push_word(CH_BACKSLASH, 1'b0, 1'b0);
        push_word(simple[$urandom_range(7)], 1'b0, 1'b0);
      end
      5: begin
        c = 8'($urandom_range(255));
        push_word(CH_BACKSLASH, 1'b0, 1'b0);
        push_word(c, 1'b0, 1'b0);
      end
      6, 7, 8: push_random_unicode();
      default: push_broken_unicode();
    endcase
  endtask

  // Random strings: mostly well formed, some cut off inside an escape, some
  // left without a final word so that the next start has to clean up.
  task automatic build_random_strings(input int word_budget);
    int base;
    int tokens;
    base = pending_words.size();
    while (pending_words.size() - base < word_budget) begin
      if ($urandom_range(19) == 0) begin
        // A one-word string: start and final on the same word.
        push_word(8'($urandom_range(255)), 1'b1, 1'b1);
        continue;
      end
      if ($urandom_range(9) == 0) push_word(8'($urandom_range(255)), 1'b1, 1'b0);
      else push_word(CH_QUOTE, 1'b1, 1'b0);
      tokens = $urandom_range(6, 1);
      for (int t = 0; t < tokens; t++) push_token();
      case ($urandom_range(9))
        0: push_word(CH_BACKSLASH, 1'b0, 1'b1);
        1: begin
          push_text("\\u");
          push_word(hex_char(4'($urandom_range(15))), 1'b0, 1'b1);
        end
        2: ;
        default: push_word(CH_QUOTE, 1'b0, 1'b1);
      endcase
    end
  endtask

  // Sender: may offer a new word once the previous one was taken or the line is
  // idle, and holds the payload steady while it is stalled.
  always @(negedge clk) begin
    str_word_t w;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_words.size() != 0 && (quiet || holding || $urandom_range(99) >= 32)) begin
        w = pending_words.pop_front();
        in_valid        <= 1'b1;
        in_char_byte    <= w.ch;
        in_string_start <= w.first;
        in_string_final <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once traffic is under
  // way so that the output queue fills and the decoder stalls its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && !hold_done && words_taken >= 100) begin
        hold_left = 60;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
        holding   <= 1'b1;
      end else begin
        holding   <= 1'b0;
        out_stall <= !quiet && ($urandom_range(99) < 32);
      end
    end
  end

  // Monitor: predicts from every accepted word first, so that a byte
  // leaving in the same cycle would still find its expectation, then checks
  // every accepted output byte against the oldest one due.
  always @(posedge clk) begin
    utf8_byte_t exp_b;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && in_stall) input_stall_cycles++;
      if (in_valid && !in_stall) begin
        unescape_word(in_char_byte, in_string_start, in_string_final);
        words_taken <= words_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected output byte %02h (last_in_run %0b)", out_byte, out_last_in_run);
          fail_count++;
        end else begin
          exp_b = bytes_due.pop_front();
          bytes_checked++;
          if (out_byte !== exp_b.data) begin
            $error("out_byte mismatch: expected %02h, got %02h", exp_b.data, out_byte);
            fail_count++;
          end
          if (out_last_in_run !== exp_b.last) begin
            $error("out_last_in_run mismatch: expected %0b, got %0b",
                   exp_b.last, out_last_in_run);
            fail_count++;
          end
        end
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_char_byte    = '0;
    in_string_start = 1'b0;
    in_string_final = 1'b0;
    out_stall       = 1'b0;
    words_taken     = 0;
    bytes_checked   = 0;
    unicode_runs    = 0;
    three_byte_runs = 0;
    input_stall_cycles = 0;
    fail_count      = 0;
    hold_left       = 0;
    hold_done       = 1'b0;
    holding         = 1'b0;
    in_taken        = 1'b0;
    clear_decoder();

    // Directed opening: the dropped opening quote, the byte extremes, a
    // known and an unknown escape, a two-byte and a mixed-case surrogate
    // escape, one cut short by a non-hex digit (leaving a small value that
    // must come out as a single byte), an escape cut off by the final word,
    // and a start that discards an escape left open.
    push_word(CH_QUOTE, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'hFF, 1'b0, 1'b0);
    push_text("\\n");
    push_text("\\q");
    push_text("\\u00E9");
    push_text("\\uD83d");
    push_text("\\u4G12");
    push_word(CH_BACKSLASH, 1'b0, 1'b1);
    push_word(CH_BACKSLASH, 1'b1, 1'b0);
    push_word(CH_N, 1'b1, 1'b1);

    build_random_strings(250);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all words sent, all bytes received, then a short quiet tail
    // to catch any byte the decoder should not have produced.
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d input words and %0d output bytes, with %0d input stall cycles.",
             words_taken, bytes_checked, input_stall_cycles);
    $display("Unicode escapes decoded: %0d, of which %0d gave three bytes.",
             unicode_runs, three_byte_runs);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8.sv
tb/tb_json_string_unescape_utf8.sv
